// ===== rtl/smau_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Small matrix arithmetic unit: shared definitions
// Sizes, codes and the work-queue entry passed from front end to back end.
// ----------------------------------------------------------------------------
package smau_pkg;

   localparam int MAX_DIM     = 8;
   localparam int ELEM_WIDTH  = 32;
   localparam int DEPTH       = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int DIM_W       = $clog2(MAX_DIM);
   localparam int DIMR_W      = 4;
   localparam int MODE_W      = 2;
   localparam int ACT_W       = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int OQ_DEPTH    = 4;
   localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_B = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B = CSR_IDX_W'(4);

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD,
      MODE_SUB,
      MODE_MUL,
      MODE_CMP
   } mode_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_WR_A,
      ACT_WR_B,
      ACT_RUN,
      ACT_NONE
   } action_type;

   // Work kinds after classification; size mismatches are resolved here
   typedef enum logic [2:0] {
      KIND_WR_A,
      KIND_WR_B,
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_CMP,
      KIND_PASS,
      KIND_CMP_MIS
   } kind_type;

   typedef enum logic {
      GEN_IDLE,
      GEN_RUN
   } gen_state_type;

   typedef struct packed {
      kind_type                kind;
      logic [ADDR_W-1:0]       index;
      logic [ELEM_WIDTH-1:0]   value;
      logic [DIM_W-1:0]        ra_m1;
      logic [DIM_W-1:0]        ca_m1;
      logic [DIM_W-1:0]        cb_m1;
      logic [ADDR_W-1:0]       nlast;
   } entry_type;

endpackage
`default_nettype wire

// ===== rtl/smau_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying store writes and run commands.
// ----------------------------------------------------------------------------
interface smau_req_if;
   logic                                       valid;
   logic                                       ready;
   logic [smau_pkg::ACT_W-1:0]                 action;
   logic [smau_pkg::ADDR_W-1:0]                elem_index;
   logic signed [smau_pkg::ELEM_WIDTH-1:0]     elem_value;

   modport source (output valid, action, elem_index, elem_value, input ready);
   modport sink   (input valid, action, elem_index, elem_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/smau_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying result elements.
// ----------------------------------------------------------------------------
interface smau_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [smau_pkg::ELEM_WIDTH-1:0]     out_value;
   logic [smau_pkg::ADDR_W-1:0]                out_index;
   logic                                       is_equal;
   logic                                       size_mismatch;
   logic                                       last;

   modport source (output valid, out_value, out_index, is_equal, size_mismatch, last,
                   input ready);
   modport sink   (input valid, out_value, out_index, is_equal, size_mismatch, last,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/smau_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Holds the configuration registers, accepts requests and classifies them
// into work-queue entries with clamped sizes.
// ----------------------------------------------------------------------------
module smau_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   smau_req_if.sink                                 req_chan,
   input  wire logic                                csr_wr_en,
   input  wire logic [smau_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [smau_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output      logic                                push_valid,
   output      smau_pkg::entry_type                 push_entry,
   input  wire logic                                q_full
);

   smau_pkg::mode_type                   mode_ff;
   logic [smau_pkg::DIMR_W-1:0]          rows_a_ff;
   logic [smau_pkg::DIMR_W-1:0]          cols_a_ff;
   logic [smau_pkg::DIMR_W-1:0]          rows_b_ff;
   logic [smau_pkg::DIMR_W-1:0]          cols_b_ff;

   logic [smau_pkg::DIM_W-1:0]           ra_m1;
   logic [smau_pkg::DIM_W-1:0]           ca_m1;
   logic [smau_pkg::DIM_W-1:0]           rb_m1;
   logic [smau_pkg::DIM_W-1:0]           cb_m1;
   logic [2*smau_pkg::DIM_W+1:0]         n_elems;
   logic                                 same_size;
   logic                                 mul_fit;
   smau_pkg::kind_type                   run_kind;
   smau_pkg::action_type                 action;

   // size minus one, with zero taken as one and anything too large as the maximum
   function automatic logic [smau_pkg::DIM_W-1:0] clamp_m1(
      input logic [smau_pkg::DIMR_W-1:0] d);
      logic [smau_pkg::DIMR_W-1:0] c;
      if (d == '0) begin
         c = smau_pkg::DIMR_W'(1);
      end else if (d > smau_pkg::DIMR_W'(smau_pkg::MAX_DIM)) begin
         c = smau_pkg::DIMR_W'(smau_pkg::MAX_DIM);
      end else begin
         c = d;
      end
      return smau_pkg::DIM_W'(c - smau_pkg::DIMR_W'(1));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= smau_pkg::MODE_ADD;
         rows_a_ff <= smau_pkg::DIMR_W'(smau_pkg::MAX_DIM);
         cols_a_ff <= smau_pkg::DIMR_W'(smau_pkg::MAX_DIM);
         rows_b_ff <= smau_pkg::DIMR_W'(smau_pkg::MAX_DIM);
         cols_b_ff <= smau_pkg::DIMR_W'(smau_pkg::MAX_DIM);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            smau_pkg::CSR_MODE: begin
               mode_ff <= smau_pkg::mode_type'(csr_wdata[smau_pkg::MODE_W-1:0]);
            end
            smau_pkg::CSR_ROWS_A: begin
               rows_a_ff <= csr_wdata;
            end
            smau_pkg::CSR_COLS_A: begin
               cols_a_ff <= csr_wdata;
            end
            smau_pkg::CSR_ROWS_B: begin
               rows_b_ff <= csr_wdata;
            end
            smau_pkg::CSR_COLS_B: begin
               cols_b_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      ra_m1     = clamp_m1(rows_a_ff);
      ca_m1     = clamp_m1(cols_a_ff);
      rb_m1     = clamp_m1(rows_b_ff);
      cb_m1     = clamp_m1(cols_b_ff);
      same_size = (ra_m1 == rb_m1) && (ca_m1 == cb_m1);
      mul_fit   = (ca_m1 == rb_m1);
      n_elems   = ((2*smau_pkg::DIM_W+2)'(ra_m1) + (2*smau_pkg::DIM_W+2)'(1))
                * ((2*smau_pkg::DIM_W+2)'(ca_m1) + (2*smau_pkg::DIM_W+2)'(1));

      unique case (mode_ff)
         smau_pkg::MODE_ADD: run_kind = same_size ? smau_pkg::KIND_ADD : smau_pkg::KIND_PASS;
         smau_pkg::MODE_SUB: run_kind = same_size ? smau_pkg::KIND_SUB : smau_pkg::KIND_PASS;
         smau_pkg::MODE_MUL: run_kind = mul_fit ? smau_pkg::KIND_MUL : smau_pkg::KIND_PASS;
         smau_pkg::MODE_CMP: run_kind = same_size ? smau_pkg::KIND_CMP
                                                  : smau_pkg::KIND_CMP_MIS;
         default:            run_kind = smau_pkg::KIND_PASS;
      endcase
   end

   assign action = smau_pkg::action_type'(req_chan.action);

   always_comb begin
      push_entry.index = req_chan.elem_index;
      push_entry.value = req_chan.elem_value;
      push_entry.ra_m1 = ra_m1;
      push_entry.ca_m1 = ca_m1;
      push_entry.cb_m1 = cb_m1;
      push_entry.nlast = smau_pkg::ADDR_W'(n_elems - (2*smau_pkg::DIM_W+2)'(1));
      unique case (action)
         smau_pkg::ACT_WR_A: push_entry.kind = smau_pkg::KIND_WR_A;
         smau_pkg::ACT_WR_B: push_entry.kind = smau_pkg::KIND_WR_B;
         default:            push_entry.kind = run_kind;
      endcase
   end

   // the unused action is taken and dropped
   assign req_chan.ready = !q_full;
   assign push_valid     = req_chan.valid && !q_full && (action != smau_pkg::ACT_NONE);

endmodule
`default_nettype wire

// ===== rtl/smau_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Work queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module smau_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  wire smau_pkg::entry_type   push_entry,
   output      logic                  full,
   output      logic                  empty,
   input  wire logic                  pop,
   output      smau_pkg::entry_type   head
);

   smau_pkg::entry_type                entries [smau_pkg::QUEUE_DEPTH];
   logic [smau_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [smau_pkg::QPTR_W-1:0]        wr_ptr_in;
   logic [smau_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [smau_pkg::QPTR_W-1:0]        rd_ptr_in;
   logic [smau_pkg::QCNT_W-1:0]        count_ff;
   logic [smau_pkg::QCNT_W-1:0]        count_in;
   logic                               do_push;
   logic                               do_pop;

   assign full    = (count_ff == smau_pkg::QCNT_W'(smau_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == smau_pkg::QPTR_W'(smau_pkg::QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_ff + smau_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == smau_pkg::QPTR_W'(smau_pkg::QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_ff + smau_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + smau_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - smau_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/smau_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Back end
// Owns the A and B stores, walks the element addresses of a run, feeds a
// multiply/accumulate and add/compare datapath, and queues the results.
// ----------------------------------------------------------------------------
module smau_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_empty,
   input  wire smau_pkg::entry_type   head,
   output      logic                  q_pop,
   smau_rsp_if.source                 rsp_chan
);

   typedef struct packed {
      smau_pkg::kind_type              op;
      logic                            first_k;
      logic                            last_k;
      logic                            last_out;
      logic [smau_pkg::ADDR_W-1:0]     out_idx;
   } tag_type;

   typedef struct packed {
      logic [smau_pkg::ELEM_WIDTH-1:0] value;
      logic [smau_pkg::ADDR_W-1:0]     index;
      logic                            is_equal;
      logic                            size_mismatch;
      logic                            last;
   } result_type;

   // stores and their valid bits
   logic [smau_pkg::ELEM_WIDTH-1:0]    store_a_mem [smau_pkg::DEPTH];
   logic [smau_pkg::ELEM_WIDTH-1:0]    store_b_mem [smau_pkg::DEPTH];
   logic [smau_pkg::DEPTH-1:0]         valid_a_ff;
   logic [smau_pkg::DEPTH-1:0]         valid_b_ff;

   // sequencer
   smau_pkg::gen_state_type            gen_state_ff;
   smau_pkg::gen_state_type            gen_state_in;
   logic                               start;
   logic                               wr_a;
   logic                               wr_b;
   logic                               issue;
   logic                               is_mul;
   logic                               first_k;
   logic                               last_k;
   logic                               last_out;
   logic [smau_pkg::ADDR_W-1:0]        out_idx;
   logic [smau_pkg::ADDR_W-1:0]        rd_addr_b;
   logic [smau_pkg::ADDR_W-1:0]        ra_w;
   logic [smau_pkg::ADDR_W-1:0]        ca_w;
   smau_pkg::kind_type                 op_ff;
   logic [smau_pkg::DIM_W-1:0]         ra_m1_ff;
   logic [smau_pkg::DIM_W-1:0]         ca_m1_ff;
   logic [smau_pkg::DIM_W-1:0]         cb_m1_ff;
   logic [smau_pkg::ADDR_W-1:0]        nlast_ff;
   logic [smau_pkg::DIM_W-1:0]         i_ff;
   logic [smau_pkg::DIM_W-1:0]         k_ff;
   logic [smau_pkg::DIM_W-1:0]         j_ff;
   logic [smau_pkg::ADDR_W-1:0]        addra_ff;
   logic [smau_pkg::ADDR_W-1:0]        addrb_ff;
   logic [smau_pkg::ADDR_W-1:0]        bcol_ff;
   logic [smau_pkg::ADDR_W-1:0]        outidx_ff;
   tag_type                            issue_tag;

   // read stage
   logic                               d_vld_ff;
   tag_type                            d_tag_ff;
   logic [smau_pkg::ELEM_WIDTH-1:0]    rd_a_ff;
   logic [smau_pkg::ELEM_WIDTH-1:0]    rd_b_ff;
   logic                               va_ff;
   logic                               vb_ff;
   logic [smau_pkg::ELEM_WIDTH-1:0]    a_val;
   logic [smau_pkg::ELEM_WIDTH-1:0]    b_val;
   logic [smau_pkg::ELEM_WIDTH-1:0]    prod_lo;

   // product stage
   logic                               p_vld_ff;
   tag_type                            p_tag_ff;
   logic [smau_pkg::ELEM_WIDTH-1:0]    p_prod_ff;
   logic [smau_pkg::ELEM_WIDTH-1:0]    p_sum_ff;
   logic [smau_pkg::ELEM_WIDTH-1:0]    p_sum_in;
   logic                               p_eq_ff;

   // accumulate stage
   logic [smau_pkg::ELEM_WIDTH-1:0]    acc_ff;
   logic [smau_pkg::ELEM_WIDTH-1:0]    acc_in;
   logic                               eq_acc_ff;
   logic                               eq_acc_in;
   logic                               res_push;
   result_type                         res;

   // result queue
   result_type                         oq [smau_pkg::OQ_DEPTH];
   logic [smau_pkg::OQ_PTR_W-1:0]      oq_wptr_ff;
   logic [smau_pkg::OQ_PTR_W-1:0]      oq_rptr_ff;
   logic [smau_pkg::OQ_CNT_W-1:0]      oq_cnt_ff;
   logic [smau_pkg::OQ_CNT_W-1:0]      oq_cnt_in;
   logic [smau_pkg::OQ_CNT_W-1:0]      inflight_ff;
   logic [smau_pkg::OQ_CNT_W-1:0]      inflight_in;
   logic                               rsp_xfer;
   logic                               issue_res;
   result_type                         oq_head;

   // ---------------- sequencer ----------------

   always_comb begin
      q_pop = (gen_state_ff == smau_pkg::GEN_IDLE) && !q_empty;
      wr_a  = q_pop && (head.kind == smau_pkg::KIND_WR_A);
      wr_b  = q_pop && (head.kind == smau_pkg::KIND_WR_B);
      start = q_pop && !wr_a && !wr_b;
   end

   always_comb begin
      is_mul    = (op_ff == smau_pkg::KIND_MUL);
      ra_w      = smau_pkg::ADDR_W'(ra_m1_ff) + smau_pkg::ADDR_W'(1);
      ca_w      = smau_pkg::ADDR_W'(ca_m1_ff) + smau_pkg::ADDR_W'(1);
      rd_addr_b = is_mul ? addrb_ff : addra_ff;
      if (is_mul) begin
         first_k  = (k_ff == '0);
         last_k   = (k_ff == ca_m1_ff);
         last_out = last_k && (i_ff == ra_m1_ff) && (j_ff == cb_m1_ff);
         out_idx  = outidx_ff;
      end else if (op_ff == smau_pkg::KIND_CMP) begin
         first_k  = (addra_ff == '0);
         last_k   = (addra_ff == nlast_ff);
         last_out = last_k;
         out_idx  = '0;
      end else if (op_ff == smau_pkg::KIND_CMP_MIS) begin
         first_k  = 1'b1;
         last_k   = 1'b1;
         last_out = 1'b1;
         out_idx  = '0;
      end else begin
         first_k  = 1'b1;
         last_k   = 1'b1;
         last_out = (addra_ff == nlast_ff);
         out_idx  = addra_ff;
      end
      // hold the element that ends a result until the result queue has room
      issue = (gen_state_ff == smau_pkg::GEN_RUN)
           && (!last_k || (inflight_ff < smau_pkg::OQ_CNT_W'(smau_pkg::OQ_DEPTH)));
      issue_res = issue && last_k;
      issue_tag.op       = op_ff;
      issue_tag.first_k  = first_k;
      issue_tag.last_k   = last_k;
      issue_tag.last_out = last_out;
      issue_tag.out_idx  = out_idx;
   end

   always_comb begin
      gen_state_in = gen_state_ff;
      unique case (gen_state_ff)
         smau_pkg::GEN_IDLE: begin
            if (start) begin
               gen_state_in = smau_pkg::GEN_RUN;
            end
         end
         smau_pkg::GEN_RUN: begin
            if (issue && last_out) begin
               gen_state_in = smau_pkg::GEN_IDLE;
            end
         end
         default: begin
            gen_state_in = smau_pkg::GEN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_state_ff <= smau_pkg::GEN_IDLE;
      end else begin
         gen_state_ff <= gen_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff     <= head.kind;
         ra_m1_ff  <= head.ra_m1;
         ca_m1_ff  <= head.ca_m1;
         cb_m1_ff  <= head.cb_m1;
         nlast_ff  <= head.nlast;
         i_ff      <= '0;
         k_ff      <= '0;
         j_ff      <= '0;
         addra_ff  <= '0;
         addrb_ff  <= '0;
         bcol_ff   <= '0;
         outidx_ff <= '0;
      end else if (issue) begin
         if (!is_mul) begin
            addra_ff <= addra_ff + smau_pkg::ADDR_W'(1);
         end else if (!last_k) begin
            // step along row i of A and column j of B
            k_ff     <= k_ff + smau_pkg::DIM_W'(1);
            addra_ff <= addra_ff + ra_w;
            addrb_ff <= addrb_ff + smau_pkg::ADDR_W'(1);
         end else begin
            k_ff      <= '0;
            outidx_ff <= outidx_ff + smau_pkg::ADDR_W'(1);
            if (i_ff != ra_m1_ff) begin
               i_ff     <= i_ff + smau_pkg::DIM_W'(1);
               addra_ff <= smau_pkg::ADDR_W'(i_ff) + smau_pkg::ADDR_W'(1);
               addrb_ff <= bcol_ff;
            end else begin
               i_ff     <= '0;
               j_ff     <= j_ff + smau_pkg::DIM_W'(1);
               addra_ff <= '0;
               bcol_ff  <= bcol_ff + ca_w;
               addrb_ff <= bcol_ff + ca_w;
            end
         end
      end
   end

   // ---------------- stores ----------------

   always_ff @(posedge clock) begin
      if (wr_a) begin
         store_a_mem[head.index] <= head.value;
      end
      rd_a_ff <= store_a_mem[addra_ff];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         store_b_mem[head.index] <= head.value;
      end
      rd_b_ff <= store_b_mem[rd_addr_b];
   end

   // an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= '0;
         valid_b_ff <= '0;
      end else begin
         if (wr_a) begin
            valid_a_ff[head.index] <= 1'b1;
         end
         if (wr_b) begin
            valid_b_ff[head.index] <= 1'b1;
         end
      end
   end

   // ---------------- datapath ----------------

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
         p_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= issue;
         p_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_tag_ff <= issue_tag;
      va_ff    <= valid_a_ff[addra_ff];
      vb_ff    <= valid_b_ff[rd_addr_b];
   end

   always_comb begin
      a_val   = va_ff ? rd_a_ff : '0;
      b_val   = vb_ff ? rd_b_ff : '0;
      // keep the low half of the product only; it wraps like the element
      prod_lo = a_val * b_val;
      unique case (d_tag_ff.op)
         smau_pkg::KIND_ADD: p_sum_in = a_val + b_val;
         smau_pkg::KIND_SUB: p_sum_in = a_val - b_val;
         default:            p_sum_in = a_val;
      endcase
   end

   always_ff @(posedge clock) begin
      p_tag_ff  <= d_tag_ff;
      p_prod_ff <= prod_lo;
      p_sum_ff  <= p_sum_in;
      p_eq_ff   <= (a_val == b_val);
   end

   always_comb begin
      acc_in    = (p_tag_ff.first_k ? '0 : acc_ff) + p_prod_ff;
      eq_acc_in = (p_tag_ff.first_k ? 1'b1 : eq_acc_ff) && p_eq_ff;
      res_push  = p_vld_ff && p_tag_ff.last_k;
      unique case (p_tag_ff.op)
         smau_pkg::KIND_MUL:  res.value = acc_in;
         smau_pkg::KIND_ADD,
         smau_pkg::KIND_SUB,
         smau_pkg::KIND_PASS: res.value = p_sum_ff;
         default:             res.value = '0;
      endcase
      res.index         = p_tag_ff.out_idx;
      res.is_equal      = (p_tag_ff.op == smau_pkg::KIND_CMP) && eq_acc_in;
      res.size_mismatch = (p_tag_ff.op == smau_pkg::KIND_PASS)
                       || (p_tag_ff.op == smau_pkg::KIND_CMP_MIS);
      res.last          = p_tag_ff.last_out;
   end

   always_ff @(posedge clock) begin
      if (p_vld_ff) begin
         acc_ff    <= acc_in;
         eq_acc_ff <= eq_acc_in;
      end
   end

   // ---------------- result queue ----------------

   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;
   assign oq_head  = oq[oq_rptr_ff];

   always_comb begin
      oq_cnt_in   = oq_cnt_ff;
      inflight_in = inflight_ff;
      if (res_push && !rsp_xfer) begin
         oq_cnt_in = oq_cnt_ff + smau_pkg::OQ_CNT_W'(1);
      end else if (rsp_xfer && !res_push) begin
         oq_cnt_in = oq_cnt_ff - smau_pkg::OQ_CNT_W'(1);
      end
      // count results from issue until their transfer out
      if (issue_res && !rsp_xfer) begin
         inflight_in = inflight_ff + smau_pkg::OQ_CNT_W'(1);
      end else if (rsp_xfer && !issue_res) begin
         inflight_in = inflight_ff - smau_pkg::OQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wptr_ff  <= '0;
         oq_rptr_ff  <= '0;
         oq_cnt_ff   <= '0;
         inflight_ff <= '0;
      end else begin
         oq_cnt_ff   <= oq_cnt_in;
         inflight_ff <= inflight_in;
         if (res_push) begin
            oq_wptr_ff <= (oq_wptr_ff == smau_pkg::OQ_PTR_W'(smau_pkg::OQ_DEPTH - 1))
                        ? '0 : oq_wptr_ff + smau_pkg::OQ_PTR_W'(1);
         end
         if (rsp_xfer) begin
            oq_rptr_ff <= (oq_rptr_ff == smau_pkg::OQ_PTR_W'(smau_pkg::OQ_DEPTH - 1))
                        ? '0 : oq_rptr_ff + smau_pkg::OQ_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         oq[oq_wptr_ff] <= res;
      end
   end

   assign rsp_chan.valid         = (oq_cnt_ff != '0);
   assign rsp_chan.out_value     = oq_head.value;
   assign rsp_chan.out_index     = oq_head.index;
   assign rsp_chan.is_equal      = oq_head.is_equal;
   assign rsp_chan.size_mismatch = oq_head.size_mismatch;
   assign rsp_chan.last          = oq_head.last;

endmodule
`default_nettype wire

// ===== rtl/small_matrix_arithmetic_unit_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Small matrix arithmetic unit
// Element-wise add/subtract, multiply and equality compare of two stored
// column-major signed matrices of up to 8 x 8 elements.
// ----------------------------------------------------------------------------
//  Channel    Direction  Handshake              Carries
//  req_chan   in         valid/ready            action, elem_index, elem_value
//  rsp_chan   out        valid/ready            out_value, out_index, is_equal,
//                                               size_mismatch, last
//  csr_*      in         csr_wr_en, no wait     csr_index, csr_wdata
//
//  The idle back end writes a store as it pops the entry. A run reads one
//  element pair a cycle while the result queue has room: add, subtract and
//  pass-through give one result a cycle, multiply one per cols_a pairs (up to
//  8), compare one after rows_a * cols_a pairs (one pair on a size mismatch).
//  Reset clears the control state and store valid bits. A stalled rsp_chan
//  holds four results, then stalls the run and the work queue.
// ----------------------------------------------------------------------------
module small_matrix_arithmetic_unit_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   smau_req_if.sink                                 req_chan,
   smau_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_wr_en,
   input  wire logic [smau_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [smau_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                  push_valid;
   smau_pkg::entry_type   push_entry;
   logic                  q_full;
   logic                  q_empty;
   logic                  q_pop;
   smau_pkg::entry_type   q_head;

   smau_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full)
   );

   smau_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (q_full),
      .empty      (q_empty),
      .pop        (q_pop),
      .head       (q_head)
   );

   smau_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .head       (q_head),
      .q_pop      (q_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
`default_nettype wire
